// File: design/dataflow_readiness_scoreboard_core_defines.svh
// Assertion macros used by the checker file drs_checker.sv.
`ifndef DATAFLOW_READINESS_SCOREBOARD_CORE_DEFINES_SVH
`define DATAFLOW_READINESS_SCOREBOARD_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DRS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scoreboard check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scoreboard check failed");

`endif

// File: design/drs_pkg.sv
package drs_pkg;

	localparam int NUM_TASKS   = 32;
	localparam int NUM_OBJECTS = 64;
	localparam int TASK_W      = $clog2(NUM_TASKS);

	localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(NUM_TASKS - 1);

	typedef logic [NUM_OBJECTS-1:0] obj_mask_t;

	// Input operation codes
	typedef enum logic [2:0] {
		FUNC_LOAD_DEP  = 3'd0,
		FUNC_LOAD_PROD = 3'd1,
		FUNC_EXEC      = 3'd2,
		FUNC_QUERY     = 3'd3,
		FUNC_CLEAR     = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_SCAN,
		ST_FLUSH,
		ST_QUERY
	} state_t;

	// One result transaction
	typedef struct packed {
		logic [4:0] ready_task;
		logic       found;
		logic       last;
	} result_t;

endpackage

// File: design/drs_in_if.sv
interface drs_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [4:0]  task_index;
	logic [63:0] object_mask;

	modport source (output valid, func, task_index, object_mask, input ready);
	modport sink (input valid, func, task_index, object_mask, output ready);
endinterface

// File: design/drs_out_if.sv
interface drs_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] ready_task;
	logic       found;
	logic       last;

	modport source (output valid, ready_task, found, last, input ready);
	modport sink (input valid, ready_task, found, last, output ready);
endinterface

// File: design/drs_ram.sv
module drs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port; read data holds when re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/dataflow_readiness_scoreboard_core.sv
// Loads and clears produce no result; a query reads the dependency RAM, then ST_QUERY pushes its
// result once the output slot is free. An executed transaction reads the product RAM, then scans
// every task through the dependency RAM's single read port, then ST_FLUSH makes the final push.
// Throughput: one transaction at a time; in_ch.ready is high only while the sequencer is idle.
// Reset (arst_n low, async) empties both mask tables via per-entry valid bits, clears the
// present-object mask and drops any pending result.
module dataflow_readiness_scoreboard_core
	import drs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	drs_in_if.sink     in_ch,
	drs_out_if.source  out_ch
);

	state_t state_q, state_d;

	logic              in_acc;
	logic              t_ok;
	logic [TASK_W-1:0] t_addr;
	obj_mask_t         in_mask;

	logic              dep_we, prod_we, dep_re, prod_re;
	logic [TASK_W-1:0] dep_ra;
	obj_mask_t         dep_rd_data, prod_rd_data;
	logic [NUM_TASKS-1:0] dep_vld_q, prod_vld_q;
	logic              dep_vld_s1, prod_vld_s1;
	obj_mask_t         dep_eff, prod_eff;

	obj_mask_t         present_q, prods_q;
	logic              clr;
	logic [TASK_W-1:0] chk_idx_q, pend_q;
	logic              have_pend_q;
	logic              hit, advance;
	logic [4:0]        t_q;
	logic              qvalid_q;

	logic              out_valid_q, out_free, push;
	result_t           res_d, res_q;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign t_ok    = int'(in_ch.task_index) < NUM_TASKS;
	assign t_addr  = TASK_W'(in_ch.task_index);
	assign in_mask = in_ch.object_mask[NUM_OBJECTS-1:0];
	assign in_ch.ready = (state_q == ST_IDLE);

	assign out_free = !out_valid_q || out_ch.ready;

	// Entries never loaded read as zero
	assign dep_eff  = dep_vld_s1 ? dep_rd_data : '0;
	assign prod_eff = prod_vld_s1 ? prod_rd_data : '0;
	assign hit      = (|(dep_eff & prods_q)) && !(|(dep_eff & ~present_q));

	drs_ram #(.WIDTH(NUM_OBJECTS), .DEPTH(NUM_TASKS)) u_dep_ram (
		.clk     (clk),
		.we      (dep_we),
		.wr_addr (t_addr),
		.wr_data (in_mask),
		.re      (dep_re),
		.rd_addr (dep_ra),
		.rd_data (dep_rd_data)
	);

	drs_ram #(.WIDTH(NUM_OBJECTS), .DEPTH(NUM_TASKS)) u_prod_ram (
		.clk     (clk),
		.we      (prod_we),
		.wr_addr (t_addr),
		.wr_data (in_mask),
		.re      (prod_re),
		.rd_addr (t_addr),
		.rd_data (prod_rd_data)
	);

	// Sequencer: next state, RAM control and result push
	always_comb begin
		state_d = state_q;
		dep_we  = 1'b0;
		prod_we = 1'b0;
		dep_re  = 1'b0;
		prod_re = 1'b0;
		dep_ra  = t_addr;
		clr     = 1'b0;
		advance = 1'b0;
		push    = 1'b0;
		res_d   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (func_t'(in_ch.func))
						FUNC_LOAD_DEP:  dep_we  = t_ok;
						FUNC_LOAD_PROD: prod_we = t_ok;
						FUNC_EXEC: begin
							if (t_ok) begin
								prod_re = 1'b1;
								state_d = ST_PROD;
							end else begin
								state_d = ST_FLUSH;
							end
						end
						FUNC_QUERY: begin
							dep_re  = 1'b1;
							state_d = ST_QUERY;
						end
						FUNC_CLEAR: clr = 1'b1;
						default: ;
					endcase
				end
			end
			ST_PROD: begin
				dep_re  = 1'b1;
				dep_ra  = '0;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// a second hit pushes the held one, so it stalls on a full slot
				if (!(hit && have_pend_q) || out_free) begin
					advance = 1'b1;
					if (hit && have_pend_q) begin
						push  = 1'b1;
						res_d = '{ready_task: 5'(pend_q), found: 1'b1, last: 1'b0};
					end
					if (chk_idx_q == LAST_TASK) begin
						state_d = ST_FLUSH;
					end else begin
						dep_re = 1'b1;
						dep_ra = chk_idx_q + 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					push    = 1'b1;
					res_d   = '{ready_task: have_pend_q ? 5'(pend_q) : 5'd0,
						found: have_pend_q, last: 1'b1};
					state_d = ST_IDLE;
				end
			end
			ST_QUERY: begin
				if (out_free) begin
					push    = 1'b1;
					res_d   = '{ready_task: t_q,
						found: qvalid_q && !(|(dep_eff & ~present_q)), last: 1'b1};
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: valid bits, present mask, pending flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_vld_q   <= '0;
			prod_vld_q  <= '0;
			present_q   <= '0;
			have_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (dep_we) begin
				dep_vld_q[t_addr] <= 1'b1;
			end
			if (prod_we) begin
				prod_vld_q[t_addr] <= 1'b1;
			end
			if (clr) begin
				present_q <= '0;
			end else if (state_q == ST_PROD) begin
				present_q <= present_q | prod_eff;
			end
			if (in_acc) begin
				have_pend_q <= 1'b0;
			end else if (advance && hit) begin
				have_pend_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (dep_re) begin
			dep_vld_s1 <= dep_vld_q[dep_ra];
		end
		if (prod_re) begin
			prod_vld_s1 <= prod_vld_q[t_addr];
		end
		if (state_q == ST_PROD) begin
			prods_q   <= prod_eff;
			chk_idx_q <= '0;
		end else if (advance) begin
			chk_idx_q <= chk_idx_q + 1'b1;
		end
		if (advance && hit) begin
			pend_q <= chk_idx_q;
		end
		if (in_acc) begin
			t_q      <= in_ch.task_index;
			qvalid_q <= t_ok;
		end
		if (push) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.ready_task = res_q.ready_task;
	assign out_ch.found      = res_q.found;
	assign out_ch.last       = res_q.last;

endmodule

// File: design/drs_checker.sv
`include "dataflow_readiness_scoreboard_core_defines.svh"

module drs_checker
	import drs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [2:0] in_func,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] out_ready_task,
	input logic       out_found,
	input logic       out_last
);

	// Stalled result keeps its payload
	`DRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ready_task) && $stable(out_found) && $stable(out_last))

	// A not-found result always closes its transaction's result list
	`DRS_ASSERT_NOW(a_nf_last, out_valid && !out_found, out_last)

	// Executed and query transactions occupy the sequencer
	`DRS_ASSERT_NEXT(a_busy, in_valid && in_ready && (in_func == FUNC_EXEC || in_func == FUNC_QUERY), !in_ready)

	// Loads and clears complete in the accepting cycle
	`DRS_ASSERT_NEXT(a_load_idle, in_valid && in_ready && (in_func == FUNC_LOAD_DEP || in_func == FUNC_LOAD_PROD || in_func == FUNC_CLEAR), in_ready)

endmodule

bind dataflow_readiness_scoreboard_core drs_checker u_drs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.in_func        (in_ch.func),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.out_ready_task (out_ch.ready_task),
	.out_found      (out_ch.found),
	.out_last       (out_ch.last)
);

// File: dv/drs_readiness_checker.sv
module drs_readiness_checker
	import drs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	drs_in_if    in_ch,
	drs_out_if   out_ch,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the scoreboard contents
	obj_mask_t dep_mask [NUM_TASKS];
	obj_mask_t prod_mask [NUM_TASKS];
	obj_mask_t present_mask;

	// Results still owed by the block, oldest first
	result_t   ready_q [$];
	result_t   got;
	result_t   want;

	initial begin
		foreach (dep_mask[i]) begin
			dep_mask[i]  = '0;
			prod_mask[i] = '0;
		end
		present_mask = '0;
	end

	// Append one owed result at the tail
	function automatic void owe_result(input result_t res);
		ready_q = {ready_q, res};
	endfunction

	// Apply one input transaction and queue the results it must cause
	function automatic void update_readiness(input logic [2:0] op,
		input logic [TASK_W-1:0] tidx, input obj_mask_t objs);
		obj_mask_t products;
		int        hits;
		hits = 0;
		case (func_t'(op))
			FUNC_LOAD_DEP:  dep_mask[tidx] = objs;
			FUNC_LOAD_PROD: prod_mask[tidx] = objs;
			FUNC_EXEC: begin
				products = prod_mask[tidx];
				present_mask |= products;
				// dependants in ascending order, only when wholly present
				for (int i = 0; i < NUM_TASKS; i++) begin
					if ((dep_mask[i] & products) != '0 && (dep_mask[i] & ~present_mask) == '0) begin
						owe_result('{ready_task: TASK_W'(i), found: 1'b1, last: 1'b0});
						hits++;
					end
				end
				if (hits == 0)
					owe_result('{ready_task: '0, found: 1'b0, last: 1'b1});
				else
					ready_q[ready_q.size() - 1].last = 1'b1;
			end
			FUNC_QUERY: begin
				owe_result('{ready_task: tidx,
					found: (dep_mask[tidx] & ~present_mask) == '0, last: 1'b1});
			end
			FUNC_CLEAR: present_mask = '0;
			default: ;
		endcase
	endfunction

	// Predict on accepted inputs, compare accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				update_readiness(in_ch.func, in_ch.task_index, in_ch.object_mask);
			if (out_ch.valid && out_ch.ready) begin
				got = '{ready_task: out_ch.ready_task, found: out_ch.found, last: out_ch.last};
				if (ready_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result task=%0d found=%0b last=%0b",
							$realtime, got.ready_task, got.found, got.last);
				end else begin
					want = ready_q.pop_front();
					if (got.ready_task !== want.ready_task || got.found !== want.found ||
						got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result mismatch exp task=%0d found=%0b last=%0b, got task=%0d found=%0b last=%0b",
								$realtime, want.ready_task, want.found, want.last,
								got.ready_task, got.found, got.last);
					end
				end
			end
			outstanding <= ready_q.size();
		end
	end

endmodule

// File: dv/dataflow_readiness_scoreboard_core_test.sv
module dataflow_readiness_scoreboard_core_test
	import drs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_OPS  = 460;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN       = NUM_TASKS + 16;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   ops_sent;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   holds_asked;

	drs_in_if  in_ch ();
	drs_out_if out_ch ();

	dataflow_readiness_scoreboard_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	drs_readiness_checker readiness_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Result side: random back-pressure, plus a long hold when asked
	initial begin
		int holds_done;
		holds_done = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				holds_done++;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Mostly a small pool of objects so that masks overlap often
	function automatic obj_mask_t pick_objects();
		obj_mask_t m;
		int        sel;
		int        idx;
		m = '0;
		sel = $urandom_range(99);
		if (sel < 10)
			m = {$urandom, $urandom};
		else if (sel < 15)
			m = '1;
		else if (sel < 20)
			m = '0;
		else begin
			repeat ($urandom_range(1, 3)) begin
				idx = $urandom_range(11);
				m[idx < 6 ? idx : idx + 52] = 1'b1;
			end
		end
		return m;
	endfunction

	function automatic logic [TASK_W-1:0] pick_task();
		return TASK_W'($urandom_range(NUM_TASKS - 1));
	endfunction

	// Offer one transaction and hold it until accepted
	task automatic send_op(input logic [2:0] op, input logic [TASK_W-1:0] tidx,
		input obj_mask_t objs);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.func        <= op;
		in_ch.task_index  <= tidx;
		in_ch.object_mask <= objs;
		do @(posedge clk); while (!in_ch.ready);
		if (op <= FUNC_CLEAR)
			ops_sent++;
	endtask

	// Every task depends on one object; some also need further objects
	task automatic fan_out(input bit all_ready);
		obj_mask_t          key;
		logic [TASK_W-1:0]  src;
		key = '0;
		key[$urandom_range(NUM_OBJECTS - 1)] = 1'b1;
		for (int i = 0; i < NUM_TASKS; i++)
			send_op(FUNC_LOAD_DEP, TASK_W'(i),
				(all_ready || $urandom_range(3) != 0) ? key : key | pick_objects());
		src = pick_task();
		send_op(FUNC_LOAD_PROD, src, key);
		send_op(FUNC_EXEC, src, pick_objects());
	endtask

	initial begin
		bit pressure_done;
		int pick;
		pressure_done = 1'b0;
		holds_asked   = 0;
		ops_sent      = 0;
		tx_idle_pct   = 20;
		rx_idle_pct   = 67;
		arst_n        = 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.func        <= FUNC_LOAD_DEP;
		in_ch.task_index  <= '0;
		in_ch.object_mask <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tables, self and multiple dependants, clear, unknown codes
		send_op(FUNC_QUERY, '0, '0);
		send_op(FUNC_EXEC, '0, '1);
		send_op(FUNC_LOAD_DEP, LAST_TASK, '1);
		send_op(FUNC_LOAD_PROD, '0, '1);
		send_op(FUNC_LOAD_DEP, TASK_W'(1), 64'h1);
		send_op(FUNC_QUERY, LAST_TASK, '0);
		send_op(FUNC_EXEC, '0, '0);
		send_op(FUNC_QUERY, LAST_TASK, '1);
		send_op(FUNC_CLEAR, LAST_TASK, '1);
		send_op(FUNC_QUERY, LAST_TASK, '0);
		send_op(FUNC_LOAD_DEP, TASK_W'(5), {1'b1, 63'b0});
		send_op(FUNC_LOAD_PROD, TASK_W'(5), {1'b1, 63'b0});
		send_op(FUNC_EXEC, TASK_W'(5), '0);
		for (int u = FUNC_CLEAR + 1; u < 8; u++)
			send_op(3'(u), pick_task(), {$urandom, $urandom});
		send_op(FUNC_LOAD_PROD, '0, '0);
		send_op(FUNC_EXEC, '0, '1);
		send_op(FUNC_LOAD_DEP, '0, {32{2'b01}});
		send_op(FUNC_LOAD_PROD, LAST_TASK, {32{2'b10}});
		send_op(FUNC_EXEC, LAST_TASK, '0);
		send_op(FUNC_LOAD_PROD, TASK_W'(30), {32{2'b01}});
		send_op(FUNC_EXEC, TASK_W'(30), '0);
		send_op(FUNC_QUERY, TASK_W'(1), '0);

		// Random part, three idle phases
		ops_sent = 0;
		while (ops_sent < RANDOM_OPS) begin
			if (ops_sent < RANDOM_OPS / 3) begin
				tx_idle_pct = 20;
				rx_idle_pct = 67;
			end else if (ops_sent < 2 * RANDOM_OPS / 3) begin
				tx_idle_pct = 67;
				rx_idle_pct = 20;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			// Long result stall while the full fan-out keeps coming
			if (!pressure_done && ops_sent >= RANDOM_OPS / 4) begin
				pressure_done = 1'b1;
				holds_asked++;
				fan_out(1'b1);
				repeat (4) send_op(FUNC_EXEC, pick_task(), pick_objects());
			end

			pick = $urandom_range(99);
			if (pick < 45) begin
				repeat ($urandom_range(1, 4)) send_op(FUNC_LOAD_DEP, pick_task(), pick_objects());
				repeat ($urandom_range(1, 2)) send_op(FUNC_LOAD_PROD, pick_task(), pick_objects());
				repeat ($urandom_range(1, 2)) send_op(FUNC_EXEC, pick_task(), pick_objects());
				send_op(FUNC_QUERY, pick_task(), pick_objects());
			end else if (pick < 55) begin
				send_op(FUNC_CLEAR, pick_task(), pick_objects());
				send_op(FUNC_EXEC, pick_task(), pick_objects());
			end else if (pick < 58) begin
				fan_out(1'b0);
			end else if (pick < 70) begin
				send_op(FUNC_QUERY, pick_task(), pick_objects());
			end else begin
				send_op(3'($urandom_range(7)), pick_task(), {$urandom, $urandom});
			end
		end
		in_ch.valid <= 1'b0;
		@(posedge clk);

		// Drain owed results, then a tail for anything extra
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/drs_pkg.sv
design/drs_in_if.sv
design/drs_out_if.sv
design/drs_ram.sv
design/dataflow_readiness_scoreboard_core.sv
design/drs_checker.sv
dv/drs_readiness_checker.sv
dv/dataflow_readiness_scoreboard_core_test.sv
